### rtl/core/quaternion_vertex_transform_core_macros.svh
// Assertion helpers for the checks in the core's top-level file.
`ifndef QUATERNION_VERTEX_TRANSFORM_CORE_MACROS_SVH
`define QUATERNION_VERTEX_TRANSFORM_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QVT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qvt check failed");

// The consequent must hold in the cycle after the antecedent.
`define QVT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qvt check failed");

`endif

### rtl/core/qvt_pkg.sv
package qvt_pkg;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;
	localparam int ONE_Q14 = 16384;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [15:0] qpart_t;

	typedef struct packed {
		coord_t [2:0] p;
		qpart_t [3:0] q;
		coord_t [2:0] c;
	} in_item_t;

	typedef struct packed {
		coord_t [2:0] p;
		coord_t [2:0] c;
		qpart_t [3:0] n;
		logic         degen;
	} norm_item_t;

	typedef struct packed {
		coord_t [2:0] world;
		logic         degen;
		logic         sat;
	} out_item_t;

	typedef struct packed {
		logic last_vld;
		logic stall;
	} pipe_stat_t;

endpackage

### rtl/core/qvt_fifo.sv
module qvt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= din;
		end
	end

endmodule

### rtl/core/qvt_norm.sv
module qvt_norm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  qvt_pkg::in_item_t      in_item,
	output logic                   in_ready,
	output logic                   out_valid,
	output qvt_pkg::norm_item_t    out_item,
	input  logic                   out_ready,
	output qvt_pkg::pipe_stat_t    stat
);

	// Stage 1 squares, stage 2 sum, then one root bit per stage, a divider
	// setup stage, one quotient bit per stage and a final sign stage.
	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = 15;
	localparam int LAST = 2 + SQ_STEPS + 1 + DV_STEPS + 1;
	localparam int RW = 66;
	localparam int DW = 47;

	logic adv;
	logic [LAST:1] vld;
	qvt_pkg::in_item_t itm [1:LAST];

	logic [30:0] sq_s1 [4];
	logic [32:0] sum_s2;
	logic [RW-1:0] rt_rem [SQ_STEPS];
	logic [31:0] rt_root [SQ_STEPS];
	logic [DW-1:0] dv_rem [DV_STEPS+1][4];
	logic [31:0] dv_m [DV_STEPS+1];
	logic [14:0] dv_quo [DV_STEPS][4];
	qvt_pkg::qpart_t [3:0] n_out;
	logic degen_out;

	assign adv = !vld[LAST] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld[LAST];
	assign stat.last_vld = vld[LAST];
	assign stat.stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[LAST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			itm[1] <= in_item;
			for (int g = 2; g <= LAST; g++) begin
				itm[g] <= itm[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [31:0] sq;
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				sq = $signed(in_item.q[j]) * $signed(in_item.q[j]);
				sq_s1[j] <= sq[30:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= 33'(sq_s1[0]) + 33'(sq_s1[1]) + 33'(sq_s1[2]) + 33'(sq_s1[3]);
		end
	end

	// Restoring square root of sum * 2^30, one result bit per stage.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam int B = SQ_STEPS - 1 - k;
		logic [RW-1:0] rem_in, cand;
		logic [31:0] root_in;
		if (k == 0) begin : g_first
			assign rem_in = RW'(sum_s2) << 30;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in = rt_rem[k-1];
			assign root_in = rt_root[k-1];
		end
		assign cand = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_in >= cand) begin
					rt_rem[k] <= rem_in - cand;
					rt_root[k] <= root_in | (32'(1) << B);
				end else begin
					rt_rem[k] <= rem_in;
					rt_root[k] <= root_in;
				end
			end
		end
	end

	// Rounded numerator |q| * 2^29 + floor(M / 2) for each part.
	always_ff @(posedge clk) begin
		logic [16:0] mag;
		if (adv) begin
			dv_m[0] <= rt_root[SQ_STEPS-1];
			for (int j = 0; j < 4; j++) begin
				mag = itm[LAST-DV_STEPS-2].q[j][15]
					? (17'd0 - {itm[LAST-DV_STEPS-2].q[j][15], itm[LAST-DV_STEPS-2].q[j]})
					: {1'b0, itm[LAST-DV_STEPS-2].q[j]};
				dv_rem[0][j] <= (DW'(mag) << 29) + DW'(rt_root[SQ_STEPS-1] >> 1);
			end
		end
	end

	// The quotient never exceeds 2^14, so fifteen bits cover it.
	for (genvar s = 0; s < DV_STEPS; s++) begin : g_div
		localparam int B = DV_STEPS - 1 - s;
		logic [DW-1:0] cmp;
		logic [14:0] quo_in [4];
		assign cmp = DW'(dv_m[s]) << B;
		for (genvar l = 0; l < 4; l++) begin : g_lane
			if (s == 0) begin : g_first
				assign quo_in[l] = '0;
			end else begin : g_next
				assign quo_in[l] = dv_quo[s-1][l];
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					if (dv_rem[s][l] >= cmp) begin
						dv_rem[s+1][l] <= dv_rem[s][l] - cmp;
						dv_quo[s][l] <= quo_in[l] | (15'(1) << B);
					end else begin
						dv_rem[s+1][l] <= dv_rem[s][l];
						dv_quo[s][l] <= quo_in[l];
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_m[s+1] <= dv_m[s];
			end
		end
	end

	// A zero quaternion falls back to the identity rotation.
	always_ff @(posedge clk) begin
		logic dg;
		if (adv) begin
			dg = (itm[LAST-1].q == '0);
			degen_out <= dg;
			for (int j = 0; j < 4; j++) begin
				if (dg) begin
					n_out[j] <= (j == 3) ? 16'(qvt_pkg::ONE_Q14) : '0;
				end else if (itm[LAST-1].q[j][15]) begin
					n_out[j] <= 16'd0 - {1'b0, dv_quo[DV_STEPS-1][j]};
				end else begin
					n_out[j] <= {1'b0, dv_quo[DV_STEPS-1][j]};
				end
			end
		end
	end

	assign out_item.p = itm[LAST].p;
	assign out_item.c = itm[LAST].c;
	assign out_item.n = n_out;
	assign out_item.degen = degen_out;

endmodule

### rtl/core/qvt_rotate.sv
module qvt_rotate (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  qvt_pkg::norm_item_t    in_item,
	output logic                   in_ready,
	output logic                   out_valid,
	output qvt_pkg::out_item_t     out_item,
	input  logic                   out_ready,
	output qvt_pkg::pipe_stat_t    stat
);

	localparam int LAST = 9;

	logic adv;
	logic [LAST:1] vld;
	qvt_pkg::norm_item_t itm [1:LAST];

	logic signed [47:0] pa_s1 [3], pb_s1 [3];
	logic signed [48:0] d_s2 [3];
	logic signed [35:0] t_s3 [3];
	logic signed [51:0] e_s4 [3], f_s4 [3], w_s4 [3];
	logic signed [52:0] cd_s5 [3], pw_s5 [3];
	logic signed [53:0] acc_s6 [3];
	logic signed [39:0] r_s7 [3];
	logic signed [40:0] v_s8 [3];
	qvt_pkg::coord_t world_s9 [3];
	logic [2:0] sat_s9;

	assign adv = !vld[LAST] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld[LAST];
	assign stat.last_vld = vld[LAST];
	assign stat.stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[LAST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			itm[1] <= in_item;
			for (int g = 2; g <= LAST; g++) begin
				itm[g] <= itm[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [50:0] tr;
		logic signed [54:0] ar;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				// Cross product n x p, term by term.
				pa_s1[i] <= $signed(in_item.n[(i + 1) % 3]) * $signed(in_item.p[(i + 2) % 3]);
				pb_s1[i] <= $signed(in_item.n[(i + 2) % 3]) * $signed(in_item.p[(i + 1) % 3]);
				d_s2[i] <= pa_s1[i] - pb_s1[i];
				tr = $signed(d_s2[i]) * 51'sd2 + 51'sd8192;
				t_s3[i] <= 36'(tr >>> 14);
				e_s4[i] <= $signed(itm[3].n[(i + 1) % 3]) * t_s3[(i + 2) % 3];
				f_s4[i] <= $signed(itm[3].n[(i + 2) % 3]) * t_s3[(i + 1) % 3];
				w_s4[i] <= $signed(itm[3].n[3]) * t_s3[i];
				cd_s5[i] <= e_s4[i] - f_s4[i];
				pw_s5[i] <= $signed({itm[4].p[i], 14'd0}) + w_s4[i];
				acc_s6[i] <= pw_s5[i] + cd_s5[i];
				ar = acc_s6[i] + 55'sd8192;
				r_s7[i] <= 40'(ar >>> 14);
				v_s8[i] <= r_s7[i] + $signed(itm[7].c[i]);
				if (v_s8[i] > 41'sd2147483647) begin
					world_s9[i] <= 32'h7fff_ffff;
					sat_s9[i] <= 1'b1;
				end else if (v_s8[i] < -41'sd2147483648) begin
					world_s9[i] <= 32'h8000_0000;
					sat_s9[i] <= 1'b1;
				end else begin
					world_s9[i] <= v_s8[i][31:0];
					sat_s9[i] <= 1'b0;
				end
			end
		end
	end

	assign out_item.world[0] = world_s9[0];
	assign out_item.world[1] = world_s9[1];
	assign out_item.world[2] = world_s9[2];
	assign out_item.degen = itm[LAST].degen;
	assign out_item.sat = |sat_s9;

endmodule

### rtl/core/quaternion_vertex_transform_core.sv
// Channel   Direction  Handshake     Payload
// input     in         push / full   point_x..z, quat_x..w, center_x..z
// result    out        pop / empty   world_x..z, degenerate, saturated
//
// One transaction is taken per clock while full is low, and one result leaves
// per clock while pop is high and empty is low. A push passes through the
// normalizer, whose square root and divider each settle one bit per stage,
// then the middle queue, the rotation pipeline and the output queue.
// Reset is asynchronous and clears only valid bits, queue pointers and counts.
// A stalled result side fills the output queue, then stalls the rotation
// pipeline, then fills the middle queue, and only then raises full.
`include "quaternion_vertex_transform_core_macros.svh"

module quaternion_vertex_transform_core #(
	parameter int MID_DEPTH = qvt_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = qvt_pkg::OUT_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [31:0]  point_x,
	input  logic [31:0]  point_y,
	input  logic [31:0]  point_z,
	input  logic [15:0]  quat_x,
	input  logic [15:0]  quat_y,
	input  logic [15:0]  quat_z,
	input  logic [15:0]  quat_w,
	input  logic [31:0]  center_x,
	input  logic [31:0]  center_y,
	input  logic [31:0]  center_z,
	output logic         empty,
	input  logic         pop,
	output logic [31:0]  world_x,
	output logic [31:0]  world_y,
	output logic [31:0]  world_z,
	output logic         degenerate,
	output logic         saturated
);

	qvt_pkg::in_item_t in_item;
	qvt_pkg::norm_item_t norm_item, mid_item;
	qvt_pkg::out_item_t rot_item, out_item;
	qvt_pkg::pipe_stat_t norm_st, rot_st;
	logic norm_ready, norm_valid;
	logic mid_full, mid_empty, mid_pop, rot_ready;
	logic rot_valid, out_full;

	assign in_item.p[0] = point_x;
	assign in_item.p[1] = point_y;
	assign in_item.p[2] = point_z;
	assign in_item.q[0] = quat_x;
	assign in_item.q[1] = quat_y;
	assign in_item.q[2] = quat_z;
	assign in_item.q[3] = quat_w;
	assign in_item.c[0] = center_x;
	assign in_item.c[1] = center_y;
	assign in_item.c[2] = center_z;
	assign full = !norm_ready;

	qvt_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push),
		.in_item  (in_item),
		.in_ready (norm_ready),
		.out_valid(norm_valid),
		.out_item (norm_item),
		.out_ready(!mid_full),
		.stat     (norm_st)
	);

	qvt_fifo #(
		.WIDTH($bits(qvt_pkg::norm_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (norm_valid),
		.din   (norm_item),
		.full  (mid_full),
		.pop   (mid_pop),
		.dout  (mid_item),
		.empty (mid_empty)
	);

	assign mid_pop = rot_ready && !mid_empty;

	qvt_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_item  (mid_item),
		.in_ready (rot_ready),
		.out_valid(rot_valid),
		.out_item (rot_item),
		.out_ready(!out_full),
		.stat     (rot_st)
	);

	qvt_fifo #(
		.WIDTH($bits(qvt_pkg::out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rot_valid),
		.din   (rot_item),
		.full  (out_full),
		.pop   (pop),
		.dout  (out_item),
		.empty (empty)
	);

	assign world_x = out_item.world[0];
	assign world_y = out_item.world[1];
	assign world_z = out_item.world[2];
	assign degenerate = out_item.degen;
	assign saturated = out_item.sat;

	// The input side stalls only behind a full middle queue.
	`QVT_ASSERT_IMPL(a_full_from_mid, full, mid_full && norm_st.last_vld)
	// The rotation pipeline stalls only behind a full output queue.
	`QVT_ASSERT_IMPL(a_rot_stall_from_out, rot_st.stall, out_full && rot_st.last_vld)
	// A full middle queue that is not drained stays full.
	`QVT_ASSERT_NEXT(a_mid_hold, mid_full && !mid_pop, mid_full)

endmodule

### verif/tb_quaternion_vertex_transform_core.sv
`timescale 1ns / 1ps

module tb_quaternion_vertex_transform_core;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [15:0] qx, qy, qz, qw;
		logic signed [31:0] cx, cy, cz;
	} vertex_t;

	typedef struct {
		logic [31:0] wx, wy, wz;
		logic        degen;
		logic        sat;
	} world_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
	logic [31:0] center_x = '0, center_y = '0, center_z = '0;
	logic [31:0] world_x, world_y, world_z;
	logic degenerate, saturated;

	vertex_t pending_vertices[$];
	world_t  expected_points[$];
	int      error_count = 0;
	int      send_idle_pct = 0;
	int      pop_stall_pct = 0;
	int      hold_pop_cycles = 0;
	bit      stimulus_done = 1'b0;

	quaternion_vertex_transform_core i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.empty(empty), .pop(pop),
		.world_x(world_x), .world_y(world_y), .world_z(world_z),
		.degenerate(degenerate), .saturated(saturated)
	);

	always #4 clk = ~clk;

	function automatic longint round_q14(longint x);
		return (x + 64'sd8192) >>> 14;
	endfunction

	function automatic longint root_floor(longint v);
		longint res;
		longint bitv;
		res = 0;
		bitv = 64'sd1 <<< 62;
		while (bitv > v) bitv = bitv >>> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >>> 1) + bitv;
			end else begin
				res = res >>> 1;
			end
			bitv = bitv >>> 2;
		end
		return res;
	endfunction

	function automatic world_t transform_vertex(vertex_t v);
		world_t r;
		longint p[3], c[3], q[4], n[4], t[3], ct[3], acc, s, m, mag, wv;
		p[0] = v.px; p[1] = v.py; p[2] = v.pz;
		c[0] = v.cx; c[1] = v.cy; c[2] = v.cz;
		q[0] = v.qx; q[1] = v.qy; q[2] = v.qz; q[3] = v.qw;
		s = 0;
		for (int i = 0; i < 4; i++) s += q[i] * q[i];
		r.degen = (s == 0);
		r.sat = 1'b0;
		if (r.degen) begin
			n[0] = 0; n[1] = 0; n[2] = 0; n[3] = 16384;
		end else begin
			m = root_floor(s <<< 30);
			for (int i = 0; i < 4; i++) begin
				mag = (q[i] < 0 ? -q[i] : q[i]) <<< 29;
				n[i] = (mag + (m >>> 1)) / m;
				if (q[i] < 0) n[i] = -n[i];
			end
		end
		t[0] = round_q14(2 * (n[1] * p[2] - n[2] * p[1]));
		t[1] = round_q14(2 * (n[2] * p[0] - n[0] * p[2]));
		t[2] = round_q14(2 * (n[0] * p[1] - n[1] * p[0]));
		ct[0] = n[1] * t[2] - n[2] * t[1];
		ct[1] = n[2] * t[0] - n[0] * t[2];
		ct[2] = n[0] * t[1] - n[1] * t[0];
		for (int i = 0; i < 3; i++) begin
			acc = p[i] * 16384 + n[3] * t[i] + ct[i];
			wv = round_q14(acc) + c[i];
			if (wv > 64'sd2147483647) begin
				wv = 64'sd2147483647; r.sat = 1'b1;
			end else if (wv < -64'sd2147483648) begin
				wv = -64'sd2147483648; r.sat = 1'b1;
			end
			if (i == 0) r.wx = wv[31:0];
			else if (i == 1) r.wy = wv[31:0];
			else r.wz = wv[31:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("Mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Driver: a new vertex is presented once the current one is taken.
	always @(posedge clk) begin
		vertex_t v;
		if (arst_n) begin
			if (!push || !full) begin
				if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					v = pending_vertices.pop_front();
					expected_points.insert(expected_points.size(), transform_vertex(v));
					push <= 1'b1;
					point_x <= v.px; point_y <= v.py; point_z <= v.pz;
					quat_x <= v.qx; quat_y <= v.qy; quat_z <= v.qz; quat_w <= v.qw;
					center_x <= v.cx; center_y <= v.cy; center_z <= v.cz;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each popped transaction against the oldest expectation.
	always @(posedge clk) begin
		world_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_points.size() == 0) begin
					report_mismatch("unexpected result world_x", world_x, 32'h0);
				end else begin
					e = expected_points.pop_front();
					if (world_x !== e.wx) report_mismatch("world_x", world_x, e.wx);
					if (world_y !== e.wy) report_mismatch("world_y", world_y, e.wy);
					if (world_z !== e.wz) report_mismatch("world_z", world_z, e.wz);
					if (degenerate !== e.degen)
						report_mismatch("degenerate", 32'(degenerate), 32'(e.degen));
					if (saturated !== e.sat)
						report_mismatch("saturated", 32'(saturated), 32'(e.sat));
				end
			end
			if (hold_pop_cycles > 0) begin
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= pop_stall_pct);
			end
		end
	end

	// Counts down a long hold-off on the result side.
	always @(posedge clk) begin
		if (hold_pop_cycles > 0) begin
			hold_pop_cycles <= hold_pop_cycles - 1;
		end
	end

	function automatic logic [31:0] random_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(2000000) - 1000000;
			2: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
			default: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(50)
				: 32'h80000000 + $urandom_range(50);
		endcase
	endfunction

	function automatic logic [15:0] random_part();
		case ($urandom_range(3))
			0: return 16'($urandom());
			1: return 16'($urandom_range(32767) - 16384);
			2: return 16'($urandom_range(8) - 4);
			default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
		endcase
	endfunction

	task automatic add_vertex(logic [31:0] px, py, pz, logic [15:0] qx, qy, qz, qw,
		logic [31:0] cx, cy, cz);
		vertex_t v;
		v.px = px; v.py = py; v.pz = pz;
		v.qx = qx; v.qy = qy; v.qz = qz; v.qw = qw;
		v.cx = cx; v.cy = cy; v.cz = cz;
		pending_vertices.insert(pending_vertices.size(), v);
	endtask

	task automatic add_random_vertices(int count);
		for (int i = 0; i < count; i++) begin
			// Zero quaternions now and then exercise the identity path.
			if ($urandom_range(19) == 0)
				add_vertex(random_coord(), random_coord(), random_coord(), 0, 0, 0, 0,
					random_coord(), random_coord(), random_coord());
			else
				add_vertex(random_coord(), random_coord(), random_coord(),
					random_part(), random_part(), random_part(), random_part(),
					random_coord(), random_coord(), random_coord());
		end
	endtask

	task automatic wait_drained();
		while (pending_vertices.size() > 0 || expected_points.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: identity, zero quaternion, axis turns, non-unit and extremes.
		add_vertex(32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0, 16384, 0, 0, 0);
		add_vertex(32'h00010000, 32'hfffe0000, 32'h00030000, 0, 0, 0, 0,
			32'h00100000, 0, 32'hfff00000);
		add_vertex(32'h00010000, 0, 0, 0, 0, 11585, 11585, 0, 0, 0);
		add_vertex(0, 32'h00010000, 0, 16384, 0, 0, 0, 0, 0, 0);
		add_vertex(32'h00050000, 32'h00010000, 0, 0, 3, 0, 3, 0, 0, 0);
		add_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 16384,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		add_vertex(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0,
			32'h80000000, 32'h80000000, 32'h80000000);
		add_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000, 0, 0, 0);
		add_vertex(32'h7fffffff, 32'h80000000, 32'h12345678, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 32'h80000000, 32'h7fffffff, 32'h0);
		add_vertex(32'hffffffff, 32'h00000001, 32'h55555555, 16'hffff, 16'h0001,
			16'h5555, 16'haaaa, 32'haaaaaaaa, 32'h55555555, 32'hffffffff);
		add_vertex(32'h40000000, 32'hc0000000, 0, 0, 0, 16'h7fff, 1, 32'h40000000, 0, 0);
		add_vertex(0, 0, 0, 0, 0, 0, 16'h8000, 0, 0, 0);
		wait_drained();

		add_random_vertices(150);
		wait_drained();
		send_idle_pct = 54;
		add_random_vertices(130);
		wait_drained();
		send_idle_pct = 0;
		pop_stall_pct = 54;
		add_random_vertices(130);
		wait_drained();
		send_idle_pct = 20;
		pop_stall_pct = 20;
		add_random_vertices(130);
		wait_drained();

		// Long hold-off on pop so the queues fill and full rises.
		send_idle_pct = 0;
		pop_stall_pct = 0;
		hold_pop_cycles <= 300;
		add_random_vertices(100);
		wait_drained();
		repeat (80) @(posedge clk);
		stimulus_done = 1'b1;
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		if (!stimulus_done) begin
			$display("Timeout waiting for results");
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/qvt_pkg.sv
rtl/core/qvt_fifo.sv
rtl/core/qvt_norm.sv
rtl/core/qvt_rotate.sv
rtl/core/quaternion_vertex_transform_core.sv
verif/tb_quaternion_vertex_transform_core.sv
